// ===== rtl/pdct_pkg.sv =====
// types and constants shared by the pump duty-cycle timer modules
`timescale 1ns / 1ps

package pdct_pkg;

  localparam int unsigned SEC_W     = 16;
  localparam int unsigned MAN_W     = 11;
  localparam int unsigned CFG_IDX_W = 2;

  localparam logic [SEC_W-1:0] MANUAL_MAX     = 16'd1800;
  localparam logic [MAN_W-1:0] MANUAL_DEFAULT = 11'd30;

  localparam logic [SEC_W-1:0] RST_ON_SECONDS    = 16'd60;
  localparam logic [SEC_W-1:0] RST_OFF_SECONDS   = 16'd0;
  localparam logic [SEC_W-1:0] RST_TOTAL_SECONDS = 16'd60;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_ON_LEVEL     = 2'd0,
    REG_ON_SECONDS   = 2'd1,
    REG_OFF_SECONDS  = 2'd2,
    REG_TOTAL_ON     = 2'd3
  } reg_idx_t;

  typedef enum logic [2:0] {
    KIND_TICK   = 3'd0,
    KIND_START  = 3'd1,
    KIND_MSTART = 3'd2,
    KIND_MSTOP  = 3'd3,
    KIND_ABORT  = 3'd4
  } kind_t;

  typedef enum logic [1:0] {
    PH_IDLE   = 2'd0,
    PH_ON     = 2'd1,
    PH_OFF    = 2'd2,
    PH_MANUAL = 2'd3
  } phase_t;

  typedef enum logic [2:0] {
    ST_IDLE    = 3'd0,
    ST_BUSY    = 3'd1,
    ST_DONE    = 3'd2,
    ST_ABORT   = 3'd3,
    ST_INVALID = 3'd4
  } status_t;

  typedef struct packed {
    logic             on_level;
    logic [SEC_W-1:0] on_seconds;
    logic [SEC_W-1:0] off_seconds;
    logic [SEC_W-1:0] total_on_seconds;
  } cfg_t;

  typedef struct packed {
    phase_t           phase;
    logic [SEC_W-1:0] phase_count;
    logic [SEC_W-1:0] phase_target;
    logic [SEC_W-1:0] on_total;
    logic [MAN_W-1:0] manual_remaining;
    logic             pump_on;
    status_t          last_status;
  } tmr_state_t;

endpackage

// ===== rtl/pdct_step.sv =====
// next-state logic for one event or tick of the pump timer
`timescale 1ns / 1ps

module pdct_step
  import pdct_pkg::*;
(
  input  tmr_state_t        cur,
  input  cfg_t              cfg,
  input  logic [2:0]        kind,
  input  logic [SEC_W-1:0]  duration,
  output tmr_state_t        nxt
);

  // start an ON phase from the given accumulated time, or close the cycle
  function automatic tmr_state_t begin_on(input tmr_state_t s, input cfg_t c,
                                          input logic [SEC_W-1:0] tot);
    tmr_state_t       r;
    logic [SEC_W-1:0] left;
    r          = s;
    r.on_total = tot;
    left       = c.total_on_seconds - tot;
    if (tot >= c.total_on_seconds) begin
      r.phase       = PH_IDLE;
      r.pump_on     = 1'b0;
      r.last_status = ST_DONE;
    end else if (c.on_seconds == '0) begin
      r.phase       = PH_IDLE;
      r.pump_on     = 1'b0;
      r.last_status = ST_ABORT;
    end else begin
      r.phase_target = (c.on_seconds < left) ? c.on_seconds : left;
      r.phase_count  = '0;
      r.phase        = PH_ON;
      r.pump_on      = 1'b1;
      r.last_status  = ST_BUSY;
    end
    return r;
  endfunction

  logic             in_cycle;
  logic [SEC_W-1:0] cnt_inc;
  logic [SEC_W-1:0] tot_inc;
  logic [MAN_W-1:0] rem_dec;
  logic [MAN_W-1:0] man_dur;

  assign in_cycle = (cur.phase == PH_ON) || (cur.phase == PH_OFF);
  assign cnt_inc  = cur.phase_count + 1'b1;
  assign tot_inc  = cur.on_total + 1'b1;
  assign rem_dec  = (cur.manual_remaining != '0) ? cur.manual_remaining - 1'b1
                                                 : cur.manual_remaining;
  assign man_dur  = (duration == '0 || duration > MANUAL_MAX) ? MANUAL_DEFAULT
                                                              : duration[MAN_W-1:0];

  always_comb begin
    nxt = cur;
    unique case (kind)
      KIND_TICK: begin
        unique case (cur.phase)
          PH_ON: begin
            nxt.phase_count = cnt_inc;
            nxt.on_total    = tot_inc;
            if (cnt_inc >= cur.phase_target) begin
              nxt.pump_on = 1'b0;
              if (tot_inc >= cfg.total_on_seconds) begin
                nxt.phase       = PH_IDLE;
                nxt.last_status = ST_DONE;
              end else if (cfg.off_seconds == '0) begin
                nxt = begin_on(nxt, cfg, tot_inc);
              end else begin
                nxt.phase        = PH_OFF;
                nxt.phase_count  = '0;
                nxt.phase_target = cfg.off_seconds;
              end
            end
          end
          PH_OFF: begin
            nxt.phase_count = cnt_inc;
            if (cnt_inc >= cur.phase_target) begin
              nxt = begin_on(nxt, cfg, cur.on_total);
            end
          end
          PH_MANUAL: begin
            nxt.manual_remaining = rem_dec;
            if (rem_dec == '0) begin
              nxt.pump_on = 1'b0;
              nxt.phase   = PH_IDLE;
            end
          end
          default: begin
          end
        endcase
      end
      KIND_START: begin
        if (!in_cycle) begin
          if (cfg.on_seconds == '0 || cfg.total_on_seconds == '0) begin
            nxt.last_status = ST_INVALID;
          end else begin
            nxt.manual_remaining = '0;
            nxt = begin_on(nxt, cfg, '0);
          end
        end
      end
      KIND_MSTART: begin
        if (!in_cycle) begin
          nxt.manual_remaining = man_dur;
          nxt.phase            = PH_MANUAL;
          nxt.pump_on          = 1'b1;
        end
      end
      KIND_MSTOP: begin
        if (!in_cycle) begin
          nxt.manual_remaining = '0;
          nxt.phase            = PH_IDLE;
          nxt.pump_on          = 1'b0;
        end
      end
      KIND_ABORT: begin
        if (in_cycle) begin
          nxt.phase       = PH_IDLE;
          nxt.pump_on     = 1'b0;
          nxt.last_status = ST_ABORT;
        end
      end
      default: begin
      end
    endcase
  end

endmodule

// ===== rtl/pump_duty_cycle_timer.sv =====
// top level of the pump duty-cycle timer: input stage, timer state, result register
`timescale 1ns / 1ps

// Each beat on the input channel is one event or one one-second tick; every beat
// produces exactly one result beat. The block takes one beat per clock cycle
// while the result side is not stalled. An accepted beat is held in the input
// register, and its result is loaded into the result register when the result
// side is free, raising out_valid; a ready receiver then takes it from there. The
// timer state is updated by a combinational add/compare path, so consecutive beats
// never wait on each other; only a stalled result side slows the input.
// pump_level uses the on_level value in force when the beat is processed.
module pump_duty_cycle_timer
  import pdct_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [SEC_W-1:0]     cfg_wdata,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  logic [2:0]           in_kind,
  input  logic [SEC_W-1:0]     in_duration,
  output logic                 out_valid,
  input  logic                 out_ready,
  output logic                 out_pump_level,
  output logic                 out_running,
  output logic [2:0]           out_cycle_status,
  output logic [SEC_W-1:0]     out_accumulated_on
);

  cfg_t             cfg_r;
  logic             s1_valid_r;
  logic [2:0]       s1_kind_r;
  logic [SEC_W-1:0] s1_dur_r;
  tmr_state_t       st_r;
  tmr_state_t       st_nxt;
  logic             out_valid_r;
  logic             out_level_r;
  logic             out_running_r;
  logic [2:0]       out_status_r;
  logic [SEC_W-1:0] out_acc_r;
  logic             out_free;
  logic             s1_fire;

  assign out_free = !out_valid_r || out_ready;
  assign s1_fire  = s1_valid_r && out_free;
  assign in_ready = !s1_valid_r || out_free;

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.on_level         <= 1'b1;
      cfg_r.on_seconds       <= RST_ON_SECONDS;
      cfg_r.off_seconds      <= RST_OFF_SECONDS;
      cfg_r.total_on_seconds <= RST_TOTAL_SECONDS;
    end else if (cfg_we) begin
      unique case (reg_idx_t'(cfg_index))
        REG_ON_LEVEL:     cfg_r.on_level         <= cfg_wdata[0];
        REG_ON_SECONDS:   cfg_r.on_seconds       <= cfg_wdata;
        REG_OFF_SECONDS:  cfg_r.off_seconds      <= cfg_wdata;
        REG_TOTAL_ON:     cfg_r.total_on_seconds <= cfg_wdata;
        default: begin
        end
      endcase
    end
  end

  // input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_ready) begin
      s1_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      s1_kind_r <= in_kind;
      s1_dur_r  <= in_duration;
    end
  end

  pdct_step u_step (
    .cur      (st_r),
    .cfg      (cfg_r),
    .kind     (s1_kind_r),
    .duration (s1_dur_r),
    .nxt      (st_nxt)
  );

  // timer state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r.phase            <= PH_IDLE;
      st_r.phase_count      <= '0;
      st_r.phase_target     <= '0;
      st_r.on_total         <= '0;
      st_r.manual_remaining <= '0;
      st_r.pump_on          <= 1'b0;
      st_r.last_status      <= ST_IDLE;
    end else if (s1_fire) begin
      st_r <= st_nxt;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_free) begin
      out_valid_r <= s1_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_fire) begin
      out_level_r   <= st_nxt.pump_on ? cfg_r.on_level : ~cfg_r.on_level;
      out_running_r <= st_nxt.pump_on;
      out_status_r  <= st_nxt.last_status;
      out_acc_r     <= st_nxt.on_total;
    end
  end

  assign out_valid          = out_valid_r;
  assign out_pump_level     = out_level_r;
  assign out_running        = out_running_r;
  assign out_cycle_status   = out_status_r;
  assign out_accumulated_on = out_acc_r;

  // pump is logically on exactly in an ON phase or a manual run
  a_pump_matches_phase: assert property (@(posedge clk) disable iff (!rst_n)
    st_r.pump_on == ((st_r.phase == PH_ON) || (st_r.phase == PH_MANUAL)))
    else $error("pump_on disagrees with phase");

  // an ON phase always has time left in it
  a_on_phase_bounded: assert property (@(posedge clk) disable iff (!rst_n)
    (st_r.phase == PH_ON) |-> (st_r.phase_count < st_r.phase_target))
    else $error("ON phase count reached target without ending");

  // a manual run never sits with zero seconds left
  a_manual_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    (st_r.phase == PH_MANUAL) |-> (st_r.manual_remaining != '0))
    else $error("manual run with no time remaining");

  // a beat held in the input register is not dropped while the result side stalls
  a_s1_held: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_valid_r && !out_free) |=> (s1_valid_r && $stable(s1_kind_r)))
    else $error("input beat lost during result stall");

endmodule
